// File: rtl/core/wildcard_glob_matcher_defines.svh
// Assertion macros for the wildcard glob matcher checker
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GWM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gwm_pkg.sv
// Shared constants, types and helpers for the wildcard glob matcher
`timescale 1ns / 1ps
package gwm_pkg;

    localparam int MAX_PATTERN   = 32;
    localparam int NUM_POS       = MAX_PATTERN + 1;
    localparam int LEN_W         = $clog2(NUM_POS);
    localparam int BYTE_W        = 8;
    localparam int CFG_DATA_W    = 64;
    localparam int BYTES_PER_REG = CFG_DATA_W / BYTE_W;
    localparam int NUM_PAT_REGS  = MAX_PATTERN / BYTES_PER_REG;
    localparam int PAT_IDX_W     = $clog2(NUM_PAT_REGS);
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_0_7   = 3'd0,
        REG_PAT_8_15  = 3'd1,
        REG_PAT_16_23 = 3'd2,
        REG_PAT_24_31 = 3'd3,
        REG_LEN       = 3'd4
    } cfg_reg_t;

    localparam logic FUNC_NAME_BYTE = 1'b0;
    localparam logic FUNC_END       = 1'b1;

    localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
    localparam logic [BYTE_W-1:0] QMARK_BYTE = 8'h3F;
    localparam logic [BYTE_W-1:0] UPPER_A    = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z    = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_GAP   = 8'h20;

    // per-beat control broadcast to every cell
    typedef struct packed {
        logic advance;
        logic restart;
    } cell_ctrl_t;

    // what a cell hands to its right-hand neighbour
    typedef struct packed {
        logic carry;
        logic adv;
    } link_t;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= UPPER_A && c <= UPPER_Z)
        begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/gwm_if.sv
// Valid/ready channel interfaces for the wildcard glob matcher
`timescale 1ns / 1ps
interface gwm_item_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [gwm_pkg::BYTE_W-1:0]    name_byte;

    modport source (output valid, output func, output name_byte, input ready);
    modport sink   (input valid, input func, input name_byte, output ready);
endinterface

interface gwm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

interface gwm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gwm_pkg::CFG_IDX_W-1:0]     index;
    logic [gwm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/wildcard_glob_matcher.sv
// An end-of-name beat's result lands in the output register in the cycle after the beat is taken.
// Throughput: one beat per cycle, name bytes and end-of-name alike; while the result
// register holds a beat the receiver has not taken, item input is stalled. The per-cycle
// path is the star-skip ripple through the row of 33 position cells.
// Reset: pattern and length clear to zero, only position zero active, no result pending.
`timescale 1ns / 1ps
module wildcard_glob_matcher (
    input  logic          clk,
    input  logic          rst_n,
    gwm_cfg_if.sink       cfg,
    gwm_item_if.sink      item,
    gwm_result_if.source  result
);

    logic [gwm_pkg::BYTE_W-1:0]   pat_bytes [gwm_pkg::NUM_POS];
    logic [gwm_pkg::NUM_POS-1:0]  en;
    logic [gwm_pkg::NUM_POS-1:0]  keep;
    logic [gwm_pkg::LEN_W-1:0]    len_used;
    logic [gwm_pkg::NUM_POS-1:0]  closed;
    gwm_pkg::link_t               links [gwm_pkg::NUM_POS];
    gwm_pkg::cell_ctrl_t          ctrl;
    logic [gwm_pkg::BYTE_W-1:0]   name_fold;
    logic                         item_acc;
    logic                         byte_beat;
    logic                         end_beat;
    logic                         hit;
    logic                         start_reg;
    logic                         start_next;
    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic                         matched_reg;

    gwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pat_bytes (pat_bytes),
        .en        (en),
        .keep      (keep),
        .len_used  (len_used)
    );

    assign item.ready = ~res_valid_reg | result.ready;
    assign item_acc   = item.valid & item.ready;
    assign byte_beat  = item_acc & (item.func == gwm_pkg::FUNC_NAME_BYTE);
    assign end_beat   = item_acc & (item.func == gwm_pkg::FUNC_END);
    assign name_fold  = gwm_pkg::fold_case(item.name_byte);

    assign ctrl.advance = byte_beat;
    assign ctrl.restart = end_beat;

    // position zero's start mark enters the row as a carry into the first cell
    assign links[0].carry = start_reg;
    assign links[0].adv   = 1'b0;

    for (genvar i = 0; i < gwm_pkg::NUM_POS; i++)
    begin : g_cell
        if (i < gwm_pkg::NUM_POS - 1)
        begin : g_mid
            gwm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .pat_byte  (pat_bytes[i]),
                .name_fold (name_fold),
                .en        (en[i]),
                .keep      (keep[i]),
                .link_in   (links[i]),
                .link_out  (links[i+1]),
                .closed    (closed[i])
            );
        end
        else
        begin : g_last
            gwm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .pat_byte  (pat_bytes[i]),
                .name_fold (name_fold),
                .en        (en[i]),
                .keep      (keep[i]),
                .link_in   (links[i]),
                .link_out  (),
                .closed    (closed[i])
            );
        end
    end

    assign hit = (len_used == '0) | closed[len_used];

    always_comb
    begin
        start_next = start_reg;
        if (end_beat)
        begin
            start_next = 1'b1;
        end
        else if (byte_beat)
        begin
            start_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (end_beat)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg     <= start_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_beat)
        begin
            matched_reg <= hit;
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.matched = matched_reg;

endmodule

// File: rtl/core/gwm_cell.sv
// One pattern position: active bit, star skip and byte compare
`timescale 1ns / 1ps
module gwm_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gwm_pkg::cell_ctrl_t         ctrl,
    input  logic [gwm_pkg::BYTE_W-1:0]  pat_byte,
    input  logic [gwm_pkg::BYTE_W-1:0]  name_fold,
    input  logic                        en,
    input  logic                        keep,
    input  gwm_pkg::link_t              link_in,
    output gwm_pkg::link_t              link_out,
    output logic                        closed
);

    logic act_reg;
    logic act_next;
    logic is_star;
    logic char_hit;

    // reachable now, after following star skips from the left
    assign closed   = keep & (act_reg | link_in.carry);
    assign is_star  = (pat_byte == gwm_pkg::STAR_BYTE);
    assign char_hit = (pat_byte == gwm_pkg::QMARK_BYTE)
                    | (gwm_pkg::fold_case(pat_byte) == name_fold);

    assign link_out.carry = closed & en & is_star;
    assign link_out.adv   = closed & en & ~is_star & char_hit;

    always_comb
    begin
        act_next = act_reg;
        if (ctrl.restart)
        begin
            act_next = 1'b0;
        end
        else if (ctrl.advance)
        begin
            // a star keeps its own position; a hit on the left moves in
            act_next = link_out.carry | link_in.adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule

// File: rtl/core/gwm_cfg.sv
// Pattern and length registers with position enable decode
`timescale 1ns / 1ps
module gwm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    gwm_cfg_if.sink                       cfg,
    output logic [gwm_pkg::BYTE_W-1:0]    pat_bytes [gwm_pkg::NUM_POS],
    output logic [gwm_pkg::NUM_POS-1:0]   en,
    output logic [gwm_pkg::NUM_POS-1:0]   keep,
    output logic [gwm_pkg::LEN_W-1:0]     len_used
);

    logic [gwm_pkg::CFG_DATA_W-1:0] pat_reg [gwm_pkg::NUM_PAT_REGS];
    logic [gwm_pkg::LEN_W-1:0]      len_reg;
    logic                           wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid & cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < gwm_pkg::NUM_PAT_REGS; r++)
            begin
                pat_reg[r] <= '0;
            end
            len_reg <= '0;
        end
        else if (wr)
        begin
            if (cfg.index == gwm_pkg::REG_LEN)
            begin
                len_reg <= cfg.data[gwm_pkg::LEN_W-1:0];
            end
            else if (cfg.index < gwm_pkg::CFG_IDX_W'(gwm_pkg::NUM_PAT_REGS))
            begin
                pat_reg[cfg.index[gwm_pkg::PAT_IDX_W-1:0]] <= cfg.data;
            end
        end
    end

    assign len_used = (len_reg > gwm_pkg::LEN_W'(gwm_pkg::MAX_PATTERN))
                    ? gwm_pkg::LEN_W'(gwm_pkg::MAX_PATTERN) : len_reg;

    for (genvar i = 0; i < gwm_pkg::NUM_POS; i++)
    begin : g_pos
        assign en[i]   = (len_used >  gwm_pkg::LEN_W'(i));
        assign keep[i] = (len_used >= gwm_pkg::LEN_W'(i));
        if (i < gwm_pkg::MAX_PATTERN)
        begin : g_byte
            assign pat_bytes[i] = pat_reg[i / gwm_pkg::BYTES_PER_REG]
                [(i % gwm_pkg::BYTES_PER_REG) * gwm_pkg::BYTE_W +: gwm_pkg::BYTE_W];
        end
        else
        begin : g_tail
            // terminal position: never compared, never a star
            assign pat_bytes[i] = '0;
        end
    end

endmodule

// File: rtl/core/gwm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to the top level
`timescale 1ns / 1ps
`include "wildcard_glob_matcher_defines.svh"
module gwm_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic item_func,
    input logic result_valid,
    input logic result_ready,
    input logic result_matched
);

    logic end_acc;
    logic byte_acc;

    assign end_acc  = item_valid & item_ready & (item_func == gwm_pkg::FUNC_END);
    assign byte_acc = item_valid & item_ready & (item_func == gwm_pkg::FUNC_NAME_BYTE);

    `GWM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result_matched), "stalled result beat changed")
    `GWM_ASSERT_NEXT(a_end_gives_result, end_acc, result_valid,
        "end-of-name beat gave no result")
    `GWM_ASSERT_NEXT(a_byte_no_result, byte_acc && (!result_valid || result_ready),
        !result_valid, "name byte beat produced a result")
    `GWM_ASSERT_IMP(a_result_origin, $rose(result_valid), $past(end_acc),
        "result appeared without an end-of-name beat")
    `GWM_ASSERT_IMP(a_full_stalls, result_valid && !result_ready, !item_ready,
        "input taken while the result register is full and stalled")

endmodule

bind wildcard_glob_matcher gwm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_func      (item.func),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_matched (result.matched)
);

// File: tb/wildcard_glob_matcher_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the glob matcher: a directed table, then random patterns and names
module wildcard_glob_matcher_test;
    import gwm_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int RAND_ITEMS   = 1650;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [BYTE_W-1:0] LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z = 8'h7A;

    logic clk;
    logic rst_n;

    gwm_cfg_if    cfg_ch ();
    gwm_item_if   item_ch ();
    gwm_result_if res_ch ();

    wildcard_glob_matcher u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (res_ch)
    );

    // predictor state
    logic [CFG_DATA_W-1:0] glob_regs [NUM_PAT_REGS];
    logic [LEN_W-1:0]      glob_len;
    logic [NUM_POS-1:0]    glob_active;
    logic                  matched_q [$];

    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int items_sent   = 0;
    int rx_hold_left = 0;
    bit calm         = 0;

    typedef struct packed {
        bit                    is_cfg;
        cfg_reg_t              idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  func;
        logic [BYTE_W-1:0]     nbyte;
        bit                    typed;
        logic                  want;
    } dir_row_t;

    dir_row_t dir_tab [$];

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        err_cnt++;
    endtask

    task automatic add_row(input dir_row_t row);
        dir_tab = {dir_tab, row};
    endtask

    function automatic int used_len();
        return (glob_len > MAX_PATTERN) ? MAX_PATTERN : int'(glob_len);
    endfunction

    function automatic logic [BYTE_W-1:0] glob_byte(input int i);
        return glob_regs[i / BYTES_PER_REG][(i % BYTES_PER_REG) * BYTE_W +: BYTE_W];
    endfunction

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        return (c >= UPPER_A && c <= UPPER_Z) ? c + CASE_GAP : c;
    endfunction

    // advance the active position set by one beat; end of name yields the match bit
    task automatic glob_predict(input logic f, input logic [BYTE_W-1:0] b,
                                output bit has_res, output logic hit);
        logic [NUM_POS-1:0] reach;
        logic [NUM_POS-1:0] nxt;
        logic [BYTE_W-1:0]  p;
        int                 len;
        len = used_len();
        reach = glob_active;
        for (int i = len + 1; i < NUM_POS; i++)
            reach[i] = 1'b0;
        // star skips ripple upward
        for (int i = 0; i < len; i++)
            if (reach[i] && glob_byte(i) == STAR_BYTE)
                reach[i + 1] = 1'b1;
        has_res = 0;
        hit = 1'b0;
        if (f == FUNC_END)
        begin
            has_res = 1;
            hit = (len == 0) || reach[len];
            glob_active = NUM_POS'(1);
        end
        else
        begin
            nxt = '0;
            for (int i = 0; i < len; i++)
            begin
                if (reach[i])
                begin
                    p = glob_byte(i);
                    if (p == STAR_BYTE)
                        nxt[i] = 1'b1;
                    else if (p == QMARK_BYTE || to_lower(p) == to_lower(b))
                        nxt[i + 1] = 1'b1;
                end
            end
            glob_active = nxt;
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        if (idx == REG_LEN)
            glob_len = val[LEN_W-1:0];
        else
            glob_regs[idx[PAT_IDX_W-1:0]] = val;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic f, input logic [BYTE_W-1:0] b,
                             input bit typed, input logic typed_val);
        bit   got;
        logic hit;
        if (!calm && $urandom_range(99) < 3)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.func      <= f;
        item_ch.name_byte <= b;
        do @(posedge clk); while (!item_ch.ready);
        glob_predict(f, b, got, hit);
        if (got)
            matched_q = {matched_q, typed ? typed_val : hit};
        items_sent++;
    endtask

    // stop offering, let every pending result land, then give the core time to settle
    task automatic wait_idle(input int settle);
        item_ch.valid <= 1'b0;
        while (matched_q.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_letter();
        logic [BYTE_W-1:0] c;
        c = LOWER_A + BYTE_W'($urandom_range(3));
        if ($urandom_range(1))
            c = c - CASE_GAP;
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_name_byte();
        return $urandom_range(1) ? pick_letter() : BYTE_W'($urandom_range(255));
    endfunction

    function automatic dir_row_t cfg_row(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1;
        r.idx    = idx;
        r.data   = v;
        return r;
    endfunction

    function automatic dir_row_t byte_row(input logic [BYTE_W-1:0] b);
        dir_row_t r;
        r = '0;
        r.func  = FUNC_NAME_BYTE;
        r.nbyte = b;
        return r;
    endfunction

    function automatic dir_row_t end_row(input bit typed, input logic want);
        dir_row_t r;
        r = '0;
        r.func  = FUNC_END;
        r.nbyte = BYTE_W'($urandom_range(255));
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // result side: check each beat, then choose ready for the next cycle
    always @(posedge clk)
    begin
        logic want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (matched_q.size() == 0)
                begin
                    report_mismatch("result beat with no expectation pending");
                end
                else
                begin
                    want = matched_q.pop_front();
                    if (res_ch.matched !== want)
                        report_mismatch($sformatf("matched %b, expected %b",
                                                  res_ch.matched, want));
                end
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    initial
    begin
        logic [BYTE_W-1:0]     pat [MAX_PATTERN];
        logic [BYTE_W-1:0]     nm [$];
        logic [BYTE_W-1:0]     c;
        logic [CFG_DATA_W-1:0] word;
        int                    plen;
        int                    eff;
        int                    n_names;
        int                    r;
        bit                    hold_done;

        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        item_ch.valid     = 1'b0;
        item_ch.func      = FUNC_NAME_BYTE;
        item_ch.name_byte = '0;
        res_ch.ready      = 1'b0;
        for (int g = 0; g < NUM_PAT_REGS; g++)
            glob_regs[g] = '0;
        glob_len    = '0;
        glob_active = NUM_POS'(1);
        hold_done   = 0;

        // empty pattern after reset: anything matches, the empty name too
        add_row(end_row(1, 1'b1));
        add_row(byte_row(8'h41));
        add_row(end_row(1, 1'b1));
        // "*x" against the empty name must not match
        add_row(cfg_row(REG_PAT_0_7, 64'h782A));
        add_row(cfg_row(REG_LEN, 64'd2));
        add_row(end_row(1, 1'b0));
        add_row(byte_row(8'h58));
        add_row(end_row(0, 1'b0));
        // full-length pattern of stars alone
        add_row(cfg_row(REG_PAT_0_7, {8{STAR_BYTE}}));
        add_row(cfg_row(REG_PAT_8_15, {8{STAR_BYTE}}));
        add_row(cfg_row(REG_PAT_16_23, {8{STAR_BYTE}}));
        add_row(cfg_row(REG_PAT_24_31, {8{STAR_BYTE}}));
        add_row(cfg_row(REG_LEN, 64'd32));
        add_row(end_row(1, 1'b1));
        add_row(byte_row(8'hFF));
        add_row(byte_row(8'h00));
        add_row(end_row(1, 1'b1));
        // length beyond the maximum clamps
        add_row(cfg_row(REG_LEN, 64'd63));
        add_row(end_row(1, 1'b1));
        add_row(byte_row(8'h01));
        add_row(end_row(0, 1'b0));
        // zero byte in pattern and name
        add_row(cfg_row(REG_PAT_0_7, 64'h0));
        add_row(cfg_row(REG_LEN, 64'd1));
        add_row(byte_row(8'h00));
        add_row(end_row(0, 1'b0));
        // high bytes compare exactly
        add_row(cfg_row(REG_PAT_0_7, 64'hC1));
        add_row(byte_row(8'hE1));
        add_row(end_row(0, 1'b0));
        add_row(byte_row(8'hC1));
        add_row(end_row(0, 1'b0));
        // "a?" with case folding and any byte
        add_row(cfg_row(REG_PAT_0_7, 64'h3F61));
        add_row(cfg_row(REG_LEN, 64'd2));
        add_row(byte_row(8'h41));
        add_row(byte_row(8'h80));
        add_row(end_row(0, 1'b0));
        // pattern swapped between the bytes of one name
        add_row(cfg_row(REG_PAT_0_7, 64'h6261));
        add_row(byte_row(8'h61));
        add_row(cfg_row(REG_PAT_0_7, 64'h6278));
        add_row(byte_row(8'h42));
        add_row(end_row(0, 1'b0));
        // all-ones data, then zero length
        add_row(cfg_row(REG_PAT_8_15, '1));
        add_row(cfg_row(REG_PAT_16_23, '1));
        add_row(cfg_row(REG_PAT_24_31, '1));
        add_row(cfg_row(REG_LEN, '1));
        add_row(byte_row(8'h61));
        add_row(end_row(0, 1'b0));
        add_row(cfg_row(REG_LEN, 64'd0));
        add_row(end_row(1, 1'b1));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
        begin
            if (dir_tab[k].is_cfg)
            begin
                wait_idle(4);
                write_reg(dir_tab[k].idx, dir_tab[k].data);
            end
            else
            begin
                send_item(dir_tab[k].func, dir_tab[k].nbyte, dir_tab[k].typed, dir_tab[k].want);
            end
        end

        items_sent = 0;
        while (items_sent < RAND_ITEMS)
        begin
            wait_idle(4);
            r = $urandom_range(99);
            if (r < 5)
                plen = 0;
            else if (r < 10)
                plen = MAX_PATTERN;
            else if (r < 14)
                plen = $urandom_range(MAX_PATTERN + 1, 63);
            else if (r < 30)
                plen = $urandom_range(9, MAX_PATTERN - 1);
            else
                plen = $urandom_range(1, 8);
            eff = (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                r = $urandom_range(99);
                if (r < 20)
                    pat[i] = STAR_BYTE;
                else if (r < 35)
                    pat[i] = QMARK_BYTE;
                else if (r < 85)
                    pat[i] = pick_letter();
                else
                    pat[i] = BYTE_W'($urandom_range(255));
            end
            for (int g = 0; g < NUM_PAT_REGS; g++)
            begin
                for (int j = 0; j < BYTES_PER_REG; j++)
                    word[j * BYTE_W +: BYTE_W] = pat[g * BYTES_PER_REG + j];
                write_reg(cfg_reg_t'(g), word);
            end
            word = {$urandom, $urandom};
            word[LEN_W-1:0] = LEN_W'(plen);
            write_reg(REG_LEN, word);

            n_names = $urandom_range(3, 12);
            for (int n = 0; n < n_names; n++)
            begin
                calm = (items_sent >= 700 && items_sent < 1000);
                if (!hold_done && items_sent >= 300)
                begin
                    hold_done = 1;
                    rx_hold_left = HOLD_CYCLES;
                end
                nm.delete();
                r = $urandom_range(99);
                if (r < 12)
                begin
                    repeat ($urandom_range(6)) nm = {nm, rand_name_byte()};
                end
                else
                begin
                    // build a name the pattern should accept, then maybe break it
                    for (int i = 0; i < eff; i++)
                    begin
                        if (pat[i] == STAR_BYTE)
                        begin
                            repeat ($urandom_range(3)) nm = {nm, rand_name_byte()};
                        end
                        else if (pat[i] == QMARK_BYTE)
                        begin
                            nm = {nm, rand_name_byte()};
                        end
                        else
                        begin
                            c = pat[i];
                            if (c >= UPPER_A && c <= UPPER_Z && $urandom_range(1))
                                c = c + CASE_GAP;
                            else if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(1))
                                c = c - CASE_GAP;
                            nm = {nm, c};
                        end
                    end
                    r = $urandom_range(99);
                    if (r < 10 && nm.size() > 0)
                        nm[$urandom_range(nm.size() - 1)] = rand_name_byte();
                    else if (r < 18 && nm.size() > 0)
                        nm.delete(nm.size() - 1);
                    else if (r < 25)
                        nm = {nm, rand_name_byte()};
                end
                foreach (nm[i])
                    send_item(FUNC_NAME_BYTE, nm[i], 0, 1'b0);
                // now and then the last name stays open across the next pattern write
                if (!(n == n_names - 1 && $urandom_range(99) < 8))
                    send_item(FUNC_END, BYTE_W'($urandom_range(255)), 0, 1'b0);
            end
        end
        calm = 0;

        wait_idle(20);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
